// ===== rtl/phx_pkg.sv =====
// Package for the Philox4x32 block generator.
// Holds op codes, register indexes, round constants and shared types.
// No dependencies.
package phx_pkg;

	localparam int ROUNDS_DEF  = 10;
	localparam int QUEUE_DEPTH = 2;
	localparam int CTR_W       = 128;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	localparam logic [31:0] MUL_A  = 32'hD2511F53;
	localparam logic [31:0] MUL_B  = 32'hCD9E8D57;
	localparam logic [31:0] WEYL_A = 32'h9E3779B9;
	localparam logic [31:0] WEYL_B = 32'hBB67AE85;

	typedef enum logic [1:0] {
		OP_GEN    = 2'd0,
		OP_SKIP   = 2'd1,
		OP_RELOAD = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_LOW  = 3'd0,
		CFG_KEY_HIGH = 3'd1,
		CFG_CTR_LOW  = 3'd2,
		CFG_CTR_HIGH = 3'd3
	} cfg_idx_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic pop;
		logic busy;
	} core_status_t;

endpackage

// ===== rtl/phx_fifo.sv =====
// Short queue of counter snapshots between front and round core.
// Depends on phx_pkg for the status type and default sizes.
module phx_fifo import phx_pkg::*; #(
	parameter int WIDTH = CTR_W,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output q_status_t        status
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign rdata        = mem_q[rd_ptr_q];
	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// ===== rtl/phx_front.sv =====
// Front end: accepts items, decodes the op and keeps the block counter.
// Generate items push a counter snapshot into the queue. Depends on phx_pkg.
module phx_front import phx_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [1:0]       op,
	input  logic [63:0]      skip_count,
	input  logic [CTR_W-1:0] start_ctr,
	output logic             push,
	output logic [CTR_W-1:0] snap
);
	logic [CTR_W-1:0] ctr_q;
	logic [CTR_W-1:0] ctr_d;

	assign snap = ctr_q;

	always_comb begin
		push  = 1'b0;
		ctr_d = ctr_q;
		case (op)
			OP_GEN: begin
				push  = accept;
				ctr_d = ctr_q + CTR_W'(1);
			end
			OP_SKIP:   ctr_d = ctr_q + {64'b0, skip_count};
			OP_RELOAD: ctr_d = start_ctr;
			default:   ctr_d = ctr_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (accept) begin
			ctr_q <= ctr_d;
		end
	end

endmodule

// ===== rtl/phx_core.sv =====
// Round core: one Philox round per cycle through two 32x32 multipliers,
// then an output register toward the result channel. Depends on phx_pkg.
module phx_core import phx_pkg::*; #(
	parameter int ROUNDS = ROUNDS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  q_status_t        q_status,
	input  logic [CTR_W-1:0] q_data,
	input  logic [31:0]      key_low,
	input  logic [31:0]      key_high,
	output core_status_t     status,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [31:0]      word0,
	output logic [31:0]      word1,
	output logic [31:0]      word2,
	output logic [31:0]      word3
);
	localparam int RW = $clog2(ROUNDS + 1);

	logic          busy_q;
	logic [RW-1:0] round_q;
	logic [31:0]   w0_q, w1_q, w2_q, w3_q;
	logic [31:0]   ka_q, kb_q;
	logic          out_valid_q;
	logic [63:0]   prod_a, prod_b;
	logic          pop, running, finish;

	assign prod_a  = {32'b0, MUL_A} * {32'b0, w0_q};
	assign prod_b  = {32'b0, MUL_B} * {32'b0, w2_q};
	assign pop     = !busy_q && !q_status.empty;
	assign running = busy_q && (round_q != RW'(ROUNDS));
	assign finish  = busy_q && (round_q == RW'(ROUNDS)) && (!out_valid_q || !out_stall);

	assign status.pop  = pop;
	assign status.busy = busy_q;
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q  <= 1'b1;
				round_q <= '0;
			end else if (running) begin
				round_q <= round_q + RW'(1);
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			w0_q <= q_data[31:0];
			w1_q <= q_data[63:32];
			w2_q <= q_data[95:64];
			w3_q <= q_data[127:96];
			ka_q <= key_low;
			kb_q <= key_high;
		end else if (running) begin
			w0_q <= prod_b[63:32] ^ w1_q ^ ka_q;
			w1_q <= prod_b[31:0];
			w2_q <= prod_a[63:32] ^ w3_q ^ kb_q;
			w3_q <= prod_a[31:0];
			ka_q <= ka_q + WEYL_A;
			kb_q <= kb_q + WEYL_B;
		end
		if (finish) begin
			word0 <= w0_q;
			word1 <= w1_q;
			word2 <= w2_q;
			word3 <= w3_q;
		end
	end

endmodule

// ===== rtl/counter_based_random_block_generator_top.sv =====
// Top level of the Philox4x32 block generator: configuration registers,
// front end, snapshot queue and round core. Depends on phx_pkg and submodules.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  op, skip_count
//   out      source     out_valid / out_stall word0..word3
//   cfg      sink       cfg_we               cfg_index, cfg_wdata
//
// Skip, reload and unused ops stay in the front end and push no snapshot.
// In the round core a generate item is loaded, runs one round per cycle
// through the shared multiplier pair, and finishes into the output register.
// Reset zeroes the counter, queue pointers, core control and config registers.
// in_stall rises while the queue is full; out_stall holds the output register.
module counter_based_random_block_generator_top import phx_pkg::*; #(
	parameter int ROUNDS = ROUNDS_DEF,
	parameter int DEPTH  = QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            op,
	input  logic [63:0]           skip_count,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [31:0]           word0,
	output logic [31:0]           word1,
	output logic [31:0]           word2,
	output logic [31:0]           word3
);
	logic [31:0]      key_low_q, key_high_q;
	logic [63:0]      start_low_q, start_high_q;
	logic             in_accept;
	logic             push;
	logic [CTR_W-1:0] snap;
	logic [CTR_W-1:0] q_data;
	q_status_t        q_status;
	core_status_t     core_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q    <= '0;
			key_high_q   <= '0;
			start_low_q  <= '0;
			start_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_LOW:  key_low_q    <= cfg_wdata[31:0];
				CFG_KEY_HIGH: key_high_q   <= cfg_wdata[31:0];
				CFG_CTR_LOW:  start_low_q  <= cfg_wdata;
				CFG_CTR_HIGH: start_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_stall  = q_status.full;
	assign in_accept = in_valid && !in_stall;

	phx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.op         (op),
		.skip_count (skip_count),
		.start_ctr  ({start_high_q, start_low_q}),
		.push       (push),
		.snap       (snap)
	);

	phx_fifo #(
		.WIDTH (CTR_W),
		.DEPTH (DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (snap),
		.pop    (core_st.pop),
		.rdata  (q_data),
		.status (q_status)
	);

	phx_core #(
		.ROUNDS (ROUNDS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.q_data    (q_data),
		.key_low   (key_low_q),
		.key_high  (key_high_q),
		.status    (core_st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.word0     (word0),
		.word1     (word1),
		.word2     (word2),
		.word3     (word3)
	);

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("push into full queue");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		core_st.pop |-> !q_status.empty)
		else $error("pop from empty queue");

	a_pop_starts_core: assert property (@(posedge clk) disable iff (!arst_n)
		core_st.pop |=> core_st.busy)
		else $error("core idle after pop");

	a_result_from_core: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(core_st.busy))
		else $error("result without a running block");

endmodule

// ===== test/tb.sv =====
// Testbench for counter_based_random_block_generator_top: drives generate, skip, reload
// and unused items under random idling and checks every block against a Philox4x32 predictor.
// Depends on phx_pkg and the RTL of the block; needs no files or arguments.
module tb;
	import phx_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = (QUEUE_DEPTH + 2) * (ROUNDS_DEF + 2) + 16;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 290;

	typedef struct packed {
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [31:0] w3;
	} block_t;

	class philox_scoreboard;
		logic [31:0] key_lo;
		logic [31:0] key_hi;
		logic [63:0] start_lo;
		logic [63:0] start_hi;
		logic [127:0] counter;
		block_t expected_blocks[$];
		int errors;

		function new();
			key_lo = '0;
			key_hi = '0;
			start_lo = '0;
			start_hi = '0;
			counter = '0;
			errors = 0;
		endfunction

		function void write_register(cfg_idx_t idx, logic [63:0] value);
			case (idx)
				CFG_KEY_LOW: key_lo = value[31:0];
				CFG_KEY_HIGH: key_hi = value[31:0];
				CFG_CTR_LOW: start_lo = value;
				CFG_CTR_HIGH: start_hi = value;
				default: ;
			endcase
		endfunction

		function block_t philox_block(logic [127:0] ctr);
			logic [31:0] w0, w1, w2, w3, ka, kb;
			logic [63:0] pa, pb;
			block_t blk;
			w0 = ctr[31:0];
			w1 = ctr[63:32];
			w2 = ctr[95:64];
			w3 = ctr[127:96];
			ka = key_lo;
			kb = key_hi;
			for (int r = 0; r < ROUNDS_DEF; r++) begin
				pa = 64'(MUL_A) * 64'(w0);
				pb = 64'(MUL_B) * 64'(w2);
				w0 = pb[63:32] ^ w1 ^ ka;
				w1 = pb[31:0];
				w2 = pa[63:32] ^ w3 ^ kb;
				w3 = pa[31:0];
				ka = ka + WEYL_A;
				kb = kb + WEYL_B;
			end
			blk.w0 = w0;
			blk.w1 = w1;
			blk.w2 = w2;
			blk.w3 = w3;
			return blk;
		endfunction

		function void note_item(logic [1:0] code, logic [63:0] amount);
			case (code)
				OP_GEN: begin
					expected_blocks.push_back(philox_block(counter));
					counter = counter + 128'd1;
				end
				OP_SKIP: counter = counter + {64'd0, amount};
				OP_RELOAD: counter = {start_hi, start_lo};
				default: ;
			endcase
		endfunction

		function void compare_word(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s expected %h actual %h", name, want, got);
				errors++;
			end
		endfunction

		function void check_block(block_t got);
			block_t want;
			if (expected_blocks.size() == 0) begin
				$error("block %h with no item pending", got);
				errors++;
				return;
			end
			want = expected_blocks.pop_front();
			compare_word("word0", want.w0, got.w0);
			compare_word("word1", want.w1, got.w1);
			compare_word("word2", want.w2, got.w2);
			compare_word("word3", want.w3, got.w3);
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] op = '0;
	logic [63:0] skip_count = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] word0, word1, word2, word3;

	bit calm = 1'b0;
	int idle_cycles = 0;
	philox_scoreboard sb = new();

	counter_based_random_block_generator_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.skip_count(skip_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.word0(word0),
		.word1(word1),
		.word2(word2),
		.word3(word3)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] pick_skip();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return {$urandom, $urandom};
		if (r < 70) return 64'($urandom_range(0, 16));
		if (r < 85) return 64'(32'hFFFF_FFFF - 32'($urandom_range(0, 4)));
		return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 4));
	endfunction

	function automatic logic [1:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return OP_GEN;
		if (r < 75) return OP_SKIP;
		if (r < 87) return OP_RELOAD;
		return OP_UNUSED;
	endfunction

	task automatic send_item(logic [1:0] code, logic [63:0] amount);
		int gap;
		in_valid <= 1'b1;
		op <= code;
		skip_count <= amount;
		do @(posedge clk); while (in_stall);
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_blocks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		sb.write_register(idx, value);
	endtask

	task automatic write_settings(logic [63:0] klo, logic [63:0] khi,
			logic [63:0] slo, logic [63:0] shi);
		write_register(CFG_KEY_LOW, klo);
		write_register(CFG_KEY_HIGH, khi);
		write_register(CFG_CTR_LOW, slo);
		write_register(CFG_CTR_HIGH, shi);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int run, hold;
		forever begin
			run = calm ? 1 :
				(($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 6));
			out_stall <= 1'b0;
			repeat (run) @(posedge clk);
			hold = calm ? 0 : pick_gap();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_block(block_t'{word0, word1, word2, word3});
			if (in_valid && !in_stall)
				sb.note_item(op, skip_count);
			if ((out_valid && !out_stall) || (in_valid && !in_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("counter_based_random_block_generator_top regression: fail");
				$finish;
			end
		end
	end

	initial begin
		logic [63:0] klo, khi, slo, shi;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_GEN, 64'd0);
		send_item(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_GEN, 64'd0);
		wait_drained();

		write_settings(64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
			64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_RELOAD, 64'd0);
		send_item(OP_GEN, 64'd0);
		send_item(OP_GEN, 64'd0);
		send_item(OP_GEN, 64'd0);
		send_item(OP_SKIP, 64'd0);
		send_item(OP_GEN, 64'd0);
		send_item(OP_SKIP, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_GEN, 64'd0);
		send_item(OP_UNUSED, 64'd5);
		send_item(OP_GEN, 64'd0);
		send_item(OP_SKIP, 64'hFFFF_FFFF);
		send_item(OP_GEN, 64'd0);
		send_item(OP_SKIP, 64'h1_0000_0000);
		send_item(OP_GEN, 64'd0);
		send_item(OP_RELOAD, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_SKIP, 64'd1);
		send_item(OP_GEN, 64'd0);
		send_item(OP_SKIP, 64'h8000_0000_0000_0000);
		send_item(OP_GEN, 64'd0);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			klo = (p == 1) ? 64'd0 : (p == 2) ? 64'hFFFF_FFFF : {$urandom, $urandom};
			khi = (p == 1) ? 64'hFFFF_FFFF : (p == 2) ? 64'd0 : {$urandom, $urandom};
			slo = (p == 3) ? 64'hFFFF_FFFF_FFFF_FF00 : {$urandom, $urandom};
			shi = (p == 3) ? 64'hFFFF_FFFF_FFFF_FFFF : (p == 4) ? 64'd0 : {$urandom, $urandom};
			write_settings(klo, khi, slo, shi);
			calm = (p == 2);
			send_item(OP_RELOAD, pick_skip());
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_item(pick_op(), pick_skip());
		end
		calm = 1'b0;
		wait_drained();

		if (sb.errors == 0 && sb.expected_blocks.size() == 0)
			$display("counter_based_random_block_generator_top regression: pass");
		else
			$display("counter_based_random_block_generator_top regression: fail");
		$finish;
	end
endmodule
